FILE: hw/rtl/obb_overlap_test_top_macros.svh
// Assertion macros for the checker file of the box overlap block.
`ifndef OBB_OVERLAP_TEST_TOP_MACROS_SVH
`define OBB_OVERLAP_TEST_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OBB_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("obb_overlap_test check failed");

// The consequent must hold in the cycle after the antecedent.
`define OBB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("obb_overlap_test check failed");

`endif

FILE: hw/rtl/obb_pkg.sv
package obb_pkg;

    localparam logic [3:0] NO_AXIS     = 4'd15;
    localparam logic [3:0] LAST_AXIS   = 4'd14;
    localparam logic [3:0] FIRST_CROSS = 4'd6;
    localparam logic [3:0] FIRST_B     = 4'd3;

    typedef enum logic [2:0] {
        OP_MAC  = 3'd0,
        OP_ABS  = 3'd1,
        OP_LEN  = 3'd2,
        OP_SETR = 3'd3,
        OP_CMP  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        DST_T  = 3'd0,
        DST_R  = 3'd1,
        DST_C0 = 3'd2,
        DST_C1 = 3'd3,
        DST_C2 = 3'd4
    } dst_t;

    typedef enum logic [1:0] {
        X_AXIS = 2'd0,
        X_C    = 2'd1,
        X_T    = 2'd2
    } xsel_t;

    typedef enum logic [1:0] {
        Y_AXIS = 2'd0,
        Y_D    = 2'd1,
        Y_EXT  = 2'd2
    } ysel_t;

    // One micro-operation of the test program.
    typedef struct packed {
        op_t        kind;
        logic       clr;
        logic       neg;
        dst_t       dst;
        xsel_t      xsel;
        logic [4:0] xidx;
        ysel_t      ysel;
        logic [4:0] yidx;
        logic       ph_end;
        logic       axis_end;
    } uop_t;

    typedef struct packed {
        logic load;
        logic iter;
        logic sign_iter;
        logic exec1;
        logic write;
    } dp_ctl_t;

    // Axis store address: box, local axis, component.
    function automatic logic [4:0] ax(input logic b, input logic [1:0] n, input logic [1:0] k);
        return {b, n, k};
    endfunction

    function automatic logic [4:0] ext_addr(input logic b, input logic [1:0] n);
        return {2'b00, b, n};
    endfunction

    // First or second of the two local axes other than skip.
    function automatic logic [1:0] other_axis(input logic [1:0] skip, input logic second);
        if (!second) begin
            return (skip == 2'd0) ? 2'd1 : 2'd0;
        end
        return (skip == 2'd2) ? 2'd1 : 2'd2;
    endfunction

    function automatic uop_t decode(input logic [3:0] axis, input logic [2:0] ph,
                                    input logic [3:0] q);
        uop_t       u;
        logic       sb;
        logic [1:0] si;
        logic [1:0] ci;
        logic [1:0] cj;
        logic [1:0] m;
        logic       tb;
        logic [1:0] tk;
        logic [1:0] qc;
        u.kind     = OP_CMP;
        u.clr      = 1'b0;
        u.neg      = 1'b0;
        u.dst      = DST_T;
        u.xsel     = X_AXIS;
        u.xidx     = 5'd0;
        u.ysel     = Y_AXIS;
        u.yidx     = 5'd0;
        u.ph_end   = 1'b0;
        u.axis_end = 1'b1;
        qc = q[1:0];
        ci = 2'd2;
        cj = 2'd2;
        if (axis < FIRST_CROSS) begin
            sb = (axis >= FIRST_B);
            si = sb ? 2'(axis - FIRST_B) : axis[1:0];
            if (ph == 3'd0) begin
                u.axis_end = 1'b0;
                if (q < 4'd3) begin
                    u.kind = OP_MAC;
                    u.clr  = (q == 4'd0);
                    u.xidx = ax(sb, si, qc);
                    u.ysel = Y_D;
                    u.yidx = {3'b000, qc};
                end else if (q == 4'd3) begin
                    u.kind = OP_LEN;
                end else begin
                    u.kind   = OP_SETR;
                    u.ysel   = Y_EXT;
                    u.yidx   = ext_addr(sb, si);
                    u.ph_end = 1'b1;
                end
            end else if (ph < 3'd4) begin
                m = 2'(ph - 3'd1);
                u.axis_end = 1'b0;
                if (q < 4'd3) begin
                    u.kind = OP_MAC;
                    u.clr  = (q == 4'd0);
                    u.xidx = ax(sb, si, qc);
                    u.ysel = Y_AXIS;
                    u.yidx = ax(!sb, m, qc);
                end else if (q == 4'd3) begin
                    u.kind = OP_ABS;
                end else begin
                    u.kind   = OP_MAC;
                    u.dst    = DST_R;
                    u.xsel   = X_T;
                    u.ysel   = Y_EXT;
                    u.yidx   = ext_addr(!sb, m);
                    u.ph_end = 1'b1;
                end
            end
        end else begin
            case (axis)
                4'd6: begin ci = 2'd0; cj = 2'd0; end
                4'd7: begin ci = 2'd0; cj = 2'd1; end
                4'd8: begin ci = 2'd0; cj = 2'd2; end
                4'd9: begin ci = 2'd1; cj = 2'd0; end
                4'd10: begin ci = 2'd1; cj = 2'd1; end
                4'd11: begin ci = 2'd1; cj = 2'd2; end
                4'd12: begin ci = 2'd2; cj = 2'd0; end
                4'd13: begin ci = 2'd2; cj = 2'd1; end
                default: begin ci = 2'd2; cj = 2'd2; end
            endcase
            if (ph == 3'd0) begin
                u.axis_end = 1'b0;
                u.kind     = OP_MAC;
                u.ysel     = Y_AXIS;
                case (q)
                    4'd0: begin
                        u.dst = DST_C0; u.clr = 1'b1;
                        u.xidx = ax(1'b0, ci, 2'd1); u.yidx = ax(1'b1, cj, 2'd2);
                    end
                    4'd1: begin
                        u.dst = DST_C0; u.neg = 1'b1;
                        u.xidx = ax(1'b0, ci, 2'd2); u.yidx = ax(1'b1, cj, 2'd1);
                    end
                    4'd2: begin
                        u.dst = DST_C1; u.clr = 1'b1;
                        u.xidx = ax(1'b0, ci, 2'd2); u.yidx = ax(1'b1, cj, 2'd0);
                    end
                    4'd3: begin
                        u.dst = DST_C1; u.neg = 1'b1;
                        u.xidx = ax(1'b0, ci, 2'd0); u.yidx = ax(1'b1, cj, 2'd2);
                    end
                    4'd4: begin
                        u.dst = DST_C2; u.clr = 1'b1;
                        u.xidx = ax(1'b0, ci, 2'd0); u.yidx = ax(1'b1, cj, 2'd1);
                    end
                    4'd5: begin
                        u.dst = DST_C2; u.neg = 1'b1;
                        u.xidx = ax(1'b0, ci, 2'd1); u.yidx = ax(1'b1, cj, 2'd0);
                    end
                    4'd6, 4'd7, 4'd8: begin
                        u.clr  = (q == 4'd6);
                        u.xsel = X_C;
                        u.xidx = {3'b000, 2'(q - 4'd6)};
                        u.ysel = Y_D;
                        u.yidx = {3'b000, 2'(q - 4'd6)};
                    end
                    4'd9: begin
                        u.kind = OP_LEN;
                    end
                    default: begin
                        u.kind   = OP_SETR;
                        u.clr    = 1'b1;
                        u.ph_end = 1'b1;
                    end
                endcase
            end else if (ph < 3'd5) begin
                m  = 2'(ph - 3'd1);
                tb = m[1];
                tk = other_axis(tb ? cj : ci, m[0]);
                u.axis_end = 1'b0;
                if (q < 4'd3) begin
                    u.kind = OP_MAC;
                    u.clr  = (q == 4'd0);
                    u.xsel = X_C;
                    u.xidx = {3'b000, qc};
                    u.ysel = Y_AXIS;
                    u.yidx = ax(tb, tk, qc);
                end else if (q == 4'd3) begin
                    u.kind = OP_ABS;
                end else begin
                    u.kind   = OP_MAC;
                    u.dst    = DST_R;
                    u.xsel   = X_T;
                    u.ysel   = Y_EXT;
                    u.yidx   = ext_addr(tb, tk);
                    u.ph_end = 1'b1;
                end
            end
        end
        return u;
    endfunction

endpackage

FILE: hw/rtl/obb_overlap_test_top.sv
// Channel | Handshake          | Payload
// s_      | s_valid / s_ready  | box, slot, comp_x, comp_y, comp_z, half_len, last
// m_      | m_valid / m_ready  | overlap, separating_axis
//
// A load word without last is stored and gives no result.
// A word with last runs the test on one shared shift-add multiplier: each
// micro-operation passes through the fetch, load, execute and write states,
// and a multiply shifts and adds through every multiplier bit in its execute state.
// The test stops at the first separating axis. s_ready is low while it runs.
// aresetn is synchronous and active low; the vector stores are not cleared.
module obb_overlap_test_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_box,
    input  logic [1:0]         s_slot,
    input  logic signed [31:0] s_comp_x,
    input  logic signed [31:0] s_comp_y,
    input  logic signed [31:0] s_comp_z,
    input  logic [30:0]        s_half_len,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_overlap,
    output logic [3:0]         m_separating_axis
);
    import obb_pkg::*;

    logic                          accept;
    logic                          start;
    logic                          idle;
    logic                          gt;
    uop_t                          uop;
    dp_ctl_t                       ctl;
    logic signed [COORD_WIDTH-1:0] fit_x;
    logic signed [COORD_WIDTH-1:0] fit_y;
    logic signed [COORD_WIDTH-1:0] fit_z;
    logic [COORD_WIDTH-2:0]        fit_half;
    logic signed [COORD_WIDTH-1:0] x_axis;
    logic signed [COORD_WIDTH-1:0] y_axis;
    logic signed [COORD_WIDTH:0]   d_val;
    logic [COORD_WIDTH-2:0]        ext_val;

    assign s_ready = idle;
    assign accept  = s_valid && s_ready;
    assign start   = accept && s_last;

    assign fit_x    = COORD_WIDTH'(s_comp_x);
    assign fit_y    = COORD_WIDTH'(s_comp_y);
    assign fit_z    = COORD_WIDTH'(s_comp_z);
    assign fit_half = (COORD_WIDTH - 1)'(s_half_len);

    obb_store #(.COORD_WIDTH(COORD_WIDTH)) u_store (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_box  (s_box),
        .wr_slot (s_slot),
        .wr_x    (fit_x),
        .wr_y    (fit_y),
        .wr_z    (fit_z),
        .wr_half (fit_half),
        .x_addr  (uop.xidx),
        .y_addr  (uop.yidx),
        .x_axis  (x_axis),
        .y_axis  (y_axis),
        .d_val   (d_val),
        .ext_val (ext_val)
    );

    obb_dp #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk    (aclk),
        .uop     (uop),
        .ctl     (ctl),
        .x_axis  (x_axis),
        .y_axis  (y_axis),
        .d_val   (d_val),
        .ext_val (ext_val),
        .gt      (gt)
    );

    obb_seq #(.COORD_WIDTH(COORD_WIDTH)) u_seq (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .start             (start),
        .gt                (gt),
        .m_ready           (m_ready),
        .uop               (uop),
        .ctl               (ctl),
        .idle              (idle),
        .m_valid           (m_valid),
        .m_overlap         (m_overlap),
        .m_separating_axis (m_separating_axis)
    );

endmodule

FILE: hw/rtl/obb_store.sv
module obb_store #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic                          wr_box,
    input  logic [1:0]                    wr_slot,
    input  logic signed [COORD_WIDTH-1:0] wr_x,
    input  logic signed [COORD_WIDTH-1:0] wr_y,
    input  logic signed [COORD_WIDTH-1:0] wr_z,
    input  logic [COORD_WIDTH-2:0]        wr_half,
    input  logic [4:0]                    x_addr,
    input  logic [4:0]                    y_addr,
    output logic signed [COORD_WIDTH-1:0] x_axis,
    output logic signed [COORD_WIDTH-1:0] y_axis,
    output logic signed [COORD_WIDTH:0]   d_val,
    output logic [COORD_WIDTH-2:0]        ext_val
);
    localparam int W     = COORD_WIDTH;
    localparam int ROW_W = 3 * W;
    localparam logic [1:0] CENTER_SLOT = 2'd3;

    // One row per box and local axis, components packed as z, y, x.
    logic [ROW_W-1:0] axis_mem [8];
    logic [ROW_W-1:0] x_row_reg;
    logic [ROW_W-1:0] y_row_reg;
    logic [1:0]       x_comp_reg;
    logic [1:0]       y_comp_reg;
    logic [W-2:0]     ext_reg [8];
    logic [ROW_W-1:0] ctr_reg [2];
    logic signed [W:0] d_reg;
    logic [W-2:0]     ext_out_reg;
    logic signed [W-1:0] ca;
    logic signed [W-1:0] cb;

    function automatic logic signed [W-1:0] pick(input logic [ROW_W-1:0] row,
                                                 input logic [1:0] c);
        case (c)
            2'd0: return row[W-1:0];
            2'd1: return row[2*W-1:W];
            default: return row[3*W-1:2*W];
        endcase
    endfunction

    always_ff @(posedge aclk) begin
        if (wr_en && wr_slot != CENTER_SLOT) begin
            axis_mem[{wr_box, wr_slot}] <= {wr_z, wr_y, wr_x};
        end
        x_row_reg <= axis_mem[x_addr[4:2]];
        y_row_reg <= axis_mem[y_addr[4:2]];
    end

    assign ca = pick(ctr_reg[0], y_addr[1:0]);
    assign cb = pick(ctr_reg[1], y_addr[1:0]);

    always_ff @(posedge aclk) begin
        if (wr_en && wr_slot != CENTER_SLOT) begin
            ext_reg[{wr_box, wr_slot}] <= wr_half;
        end
        if (wr_en && wr_slot == CENTER_SLOT) begin
            ctr_reg[wr_box] <= {wr_z, wr_y, wr_x};
        end
        x_comp_reg  <= x_addr[1:0];
        y_comp_reg  <= y_addr[1:0];
        d_reg       <= (W + 1)'(ca) - (W + 1)'(cb);
        ext_out_reg <= ext_reg[y_addr[2:0]];
    end

    assign x_axis  = pick(x_row_reg, x_comp_reg);
    assign y_axis  = pick(y_row_reg, y_comp_reg);
    assign d_val   = d_reg;
    assign ext_val = ext_out_reg;

endmodule

FILE: hw/rtl/obb_dp.sv
module obb_dp #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          aclk,
    input  obb_pkg::uop_t                 uop,
    input  obb_pkg::dp_ctl_t              ctl,
    input  logic signed [COORD_WIDTH-1:0] x_axis,
    input  logic signed [COORD_WIDTH-1:0] y_axis,
    input  logic signed [COORD_WIDTH:0]   d_val,
    input  logic [COORD_WIDTH-2:0]        ext_val,
    output logic                          gt
);
    import obb_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int AW = 4 * W + FRAC_BITS + 8;
    localparam int YW = W + 1;

    logic signed [AW-1:0] t_reg;
    logic signed [AW-1:0] len_reg;
    logic signed [AW-1:0] r_reg;
    logic signed [AW-1:0] c0_reg;
    logic signed [AW-1:0] c1_reg;
    logic signed [AW-1:0] c2_reg;
    logic signed [AW-1:0] w_reg;
    logic signed [AW-1:0] x_reg;
    logic signed [YW-1:0] y_reg;

    logic signed [AW-1:0] x_src;
    logic signed [YW-1:0] y_src;
    logic signed [AW-1:0] dst_val;
    logic [AW-1:0]        add_a;
    logic [AW-1:0]        add_b;
    logic                 add_sub;
    logic [AW-1:0]        add_sum;

    always_comb begin
        case (uop.xsel)
            X_C: begin
                case (uop.xidx[1:0])
                    2'd0: x_src = c0_reg;
                    2'd1: x_src = c1_reg;
                    default: x_src = c2_reg;
                endcase
            end
            X_T: x_src = t_reg;
            default: x_src = AW'(x_axis);
        endcase
        case (uop.ysel)
            Y_D: y_src = d_val;
            Y_EXT: y_src = YW'(ext_val);
            default: y_src = YW'(y_axis);
        endcase
        case (uop.dst)
            DST_R: dst_val = r_reg;
            DST_C0: dst_val = c0_reg;
            DST_C1: dst_val = c1_reg;
            DST_C2: dst_val = c2_reg;
            default: dst_val = t_reg;
        endcase
    end

    // The one shared adder: partial products, negation and the final compare.
    always_comb begin
        if (ctl.iter) begin
            add_a   = w_reg;
            add_b   = x_reg;
            add_sub = uop.neg ^ ctl.sign_iter;
        end else if (uop.kind == OP_CMP) begin
            add_a   = len_reg;
            add_b   = r_reg;
            add_sub = 1'b1;
        end else begin
            add_a   = '0;
            add_b   = w_reg;
            add_sub = 1'b1;
        end
        add_sum = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);
    end

    assign gt = !add_sum[AW-1] && (add_sum != '0);

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            x_reg <= x_src;
            y_reg <= y_src;
            if (uop.kind == OP_MAC) begin
                w_reg <= uop.clr ? '0 : dst_val;
            end else begin
                w_reg <= t_reg;
            end
        end
        if (ctl.iter) begin
            x_reg <= x_reg << 1;
            y_reg <= y_reg >>> 1;
            if (y_reg[0]) begin
                w_reg <= add_sum;
            end
        end
        if (ctl.exec1 && (uop.kind == OP_ABS || uop.kind == OP_LEN) && w_reg[AW-1]) begin
            w_reg <= add_sum;
        end
        if (ctl.write) begin
            case (uop.kind)
                OP_MAC: begin
                    case (uop.dst)
                        DST_R: r_reg <= w_reg;
                        DST_C0: c0_reg <= w_reg;
                        DST_C1: c1_reg <= w_reg;
                        DST_C2: c2_reg <= w_reg;
                        default: t_reg <= w_reg;
                    endcase
                end
                OP_ABS: t_reg <= w_reg;
                OP_LEN: len_reg <= w_reg << FRAC_BITS;
                OP_SETR: r_reg <= uop.clr ? '0 : (AW'(y_reg) << (2 * FRAC_BITS));
                default: ;
            endcase
        end
    end

endmodule

FILE: hw/rtl/obb_seq.sv
module obb_seq #(
    parameter int COORD_WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             gt,
    input  logic             m_ready,
    output obb_pkg::uop_t    uop,
    output obb_pkg::dp_ctl_t ctl,
    output logic             idle,
    output logic             m_valid,
    output logic             m_overlap,
    output logic [3:0]       m_separating_axis
);
    import obb_pkg::*;

    localparam int YW = COORD_WIDTH + 1;
    localparam int CW = $clog2(YW);
    localparam logic [CW-1:0] LAST_BIT = CW'(YW - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_LOAD  = 6'b000100,
        S_EXEC  = 6'b001000,
        S_WRITE = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [3:0]    axis_reg, axis_next;
    logic [2:0]    ph_reg, ph_next;
    logic [3:0]    q_reg, q_next;
    logic [CW-1:0] bit_reg, bit_next;
    logic          hit_reg, hit_next;
    logic [3:0]    res_reg, res_next;
    logic          m_valid_reg, m_valid_next;
    logic [3:0]    m_sep_reg, m_sep_next;
    logic          is_mac;

    assign uop    = decode(axis_reg, ph_reg, q_reg);
    assign is_mac = (uop.kind == OP_MAC);

    assign ctl.load      = (state_reg == S_LOAD);
    assign ctl.iter      = (state_reg == S_EXEC) && is_mac;
    assign ctl.sign_iter = (bit_reg == LAST_BIT);
    assign ctl.exec1     = (state_reg == S_EXEC) && !is_mac;
    assign ctl.write     = (state_reg == S_WRITE);

    always_comb begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        ph_next      = ph_reg;
        q_next       = q_reg;
        bit_next     = bit_reg;
        hit_next     = hit_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_sep_next   = m_sep_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_FETCH;
                    axis_next  = 4'd0;
                    ph_next    = 3'd0;
                    q_next     = 4'd0;
                end
            end
            S_FETCH: state_next = S_LOAD;
            S_LOAD: begin
                state_next = S_EXEC;
                bit_next   = '0;
            end
            S_EXEC: begin
                if (is_mac) begin
                    if (bit_reg == LAST_BIT) begin
                        state_next = S_WRITE;
                    end else begin
                        bit_next = bit_reg + CW'(1);
                    end
                end else begin
                    if (uop.kind == OP_CMP) begin
                        hit_next = gt;
                    end
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                state_next = S_FETCH;
                if (uop.axis_end) begin
                    if (hit_reg || axis_reg == LAST_AXIS) begin
                        state_next = S_DONE;
                        res_next   = hit_reg ? axis_reg : NO_AXIS;
                    end else begin
                        axis_next = axis_reg + 4'd1;
                        ph_next   = 3'd0;
                        q_next    = 4'd0;
                    end
                end else if (uop.ph_end) begin
                    ph_next = ph_reg + 3'd1;
                    q_next  = 4'd0;
                end else begin
                    q_next = q_reg + 4'd1;
                end
            end
            S_DONE: begin
                // Hold the verdict until the previous word has left.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_sep_next   = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            axis_reg    <= 4'd0;
            ph_reg      <= 3'd0;
            q_reg       <= 4'd0;
            bit_reg     <= '0;
            hit_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            axis_reg    <= axis_next;
            ph_reg      <= ph_next;
            q_reg       <= q_next;
            bit_reg     <= bit_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg   <= res_next;
        m_sep_reg <= m_sep_next;
    end

    assign idle              = (state_reg == S_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_separating_axis = m_sep_reg;
    assign m_overlap         = (m_sep_reg == NO_AXIS);

endmodule

FILE: hw/rtl/obb_overlap_test_chk.sv
`include "obb_overlap_test_top_macros.svh"

module obb_overlap_test_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_last,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_overlap,
    input logic [3:0]         m_separating_axis
);

    // A stalled result word keeps its payload.
    `OBB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_overlap) && $stable(m_separating_axis))

    // The overlap flag agrees with the axis code.
    `OBB_ASSERT_NOW(a_flag_code, aclk, aresetn, m_valid, m_overlap == (m_separating_axis == 4'd15))

    // Once a test starts the block takes no word in the next cycle.
    `OBB_ASSERT_NEXT(a_busy, aclk, aresetn, s_valid && s_ready && s_last, !s_ready)

    // A load word alone never brings out a result.
    `OBB_ASSERT_NEXT(a_no_spurious, aclk, aresetn, s_valid && s_ready && !s_last && !m_valid, !m_valid)

endmodule

bind obb_overlap_test_top obb_overlap_test_chk u_chk (.*);

FILE: tb/obb_overlap_test_top_tb.sv
`timescale 1ns / 100ps

module obb_overlap_test_top_tb;
    import obb_pkg::*;

    localparam int  N_WORDS     = 1700;
    localparam int  CYCLE_LIMIT = 40_000_000;
    localparam int  ONE         = 65536;

    typedef logic signed [191:0] wide_t;
    typedef logic [2:0][191:0]   vec_t;

    typedef struct {
        logic               box;
        logic [1:0]         slot;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [30:0]        hl;
        logic               last;
        logic               known;
        logic               ov;
        logic [3:0]         sep;
    } word_t;

    typedef struct {
        logic       ov;
        logic [3:0] sep;
    } verdict_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_box;
    logic [1:0]         s_slot;
    logic signed [31:0] s_comp_x;
    logic signed [31:0] s_comp_y;
    logic signed [31:0] s_comp_z;
    logic [30:0]        s_half_len;
    logic               s_last;
    logic               m_valid;
    logic               m_ready;
    logic               m_overlap;
    logic [3:0]         m_separating_axis;

    obb_overlap_test_top u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_box             (s_box),
        .s_slot            (s_slot),
        .s_comp_x          (s_comp_x),
        .s_comp_y          (s_comp_y),
        .s_comp_z          (s_comp_z),
        .s_half_len        (s_half_len),
        .s_last            (s_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_overlap         (m_overlap),
        .m_separating_axis (m_separating_axis)
    );

    // Local copy of the box stores.
    logic signed [31:0] axis_q[2][3][3];
    logic [30:0]        ext_q[2][3];
    logic signed [31:0] ctr_q[2][3];

    verdict_t verdict_q[$];
    word_t    plan[$];
    int       errors;
    int       cycles;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_left;

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report(input string what, input int exp_v, input int got_v);
        $display("mismatch: %s expected %0d got %0d at cycle %0d", what, exp_v, got_v, cycles);
        errors++;
    endtask

    function automatic wide_t wabs(input wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic wide_t dot(input vec_t p, input vec_t q);
        wide_t acc;
        acc = 0;
        for (int k = 0; k < 3; k++) begin
            acc += $signed(p[k]) * $signed(q[k]);
        end
        return acc;
    endfunction

    // First separating axis of the stored boxes, or NO_AXIS.
    function automatic logic [3:0] find_separating_axis();
        vec_t  a[2][3];
        wide_t h[2][3];
        vec_t  d;
        vec_t  c;
        wide_t len;
        wide_t r;
        for (int b = 0; b < 2; b++) begin
            for (int n = 0; n < 3; n++) begin
                for (int k = 0; k < 3; k++) begin
                    a[b][n][k] = wide_t'(axis_q[b][n][k]);
                end
                h[b][n] = wide_t'({1'b0, ext_q[b][n]});
            end
        end
        for (int k = 0; k < 3; k++) begin
            d[k] = wide_t'(ctr_q[0][k]) - wide_t'(ctr_q[1][k]);
        end
        for (int b = 0; b < 2; b++) begin
            for (int n = 0; n < 3; n++) begin
                len = wabs(dot(d, a[b][n])) * ONE;
                r = h[b][n] * ONE * ONE;
                for (int m = 0; m < 3; m++) begin
                    r += wabs(dot(a[b][n], a[1 - b][m])) * h[1 - b][m];
                end
                if (len > r) return 4'(b * 3 + n);
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                c[0] = $signed(a[0][i][1]) * $signed(a[1][j][2])
                     - $signed(a[0][i][2]) * $signed(a[1][j][1]);
                c[1] = $signed(a[0][i][2]) * $signed(a[1][j][0])
                     - $signed(a[0][i][0]) * $signed(a[1][j][2]);
                c[2] = $signed(a[0][i][0]) * $signed(a[1][j][1])
                     - $signed(a[0][i][1]) * $signed(a[1][j][0]);
                len = wabs(dot(d, c)) * ONE;
                r = 0;
                for (int k = 0; k < 3; k++) begin
                    if (k != i) r += wabs(dot(c, a[0][k])) * h[0][k];
                    if (k != j) r += wabs(dot(c, a[1][k])) * h[1][k];
                end
                if (len > r) return FIRST_CROSS + 4'(i * 3 + j);
            end
        end
        return NO_AXIS;
    endfunction

    function automatic word_t mk(input logic bx, input logic [1:0] sl, input int x, input int y,
                                 input int z, input logic [30:0] hl, input logic lst);
        word_t w;
        w.box = bx; w.slot = sl; w.x = x; w.y = y; w.z = z; w.hl = hl; w.last = lst;
        w.known = 1'b0; w.ov = 1'b0; w.sep = NO_AXIS;
        return w;
    endfunction

    function automatic word_t mk_known(input word_t w, input logic ov, input logic [3:0] sep);
        w.known = 1'b1; w.ov = ov; w.sep = sep;
        return w;
    endfunction

    function automatic int rand_comp(input bit full);
        if (full) return int'($urandom);
        return int'($urandom_range(0, 2 * ONE)) - ONE;
    endfunction

    function automatic word_t rand_word(input logic bx, input logic [1:0] sl, input logic lst);
        bit full;
        int span;
        full = ($urandom_range(0, 7) == 0);
        span = (sl == 2'd3) ? 16 : 1;
        return mk(bx, sl, rand_comp(full) * (full ? 1 : span), rand_comp(full) * (full ? 1 : span),
                  rand_comp(full) * (full ? 1 : span),
                  full ? 31'($urandom) : 31'($urandom_range(0, 2 * ONE)), lst);
    endfunction

    task automatic send_word(input word_t w);
        verdict_t v;
        @(negedge aclk);
        while ($urandom_range(1, 100) <= send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_box      <= w.box;
        s_slot     <= w.slot;
        s_comp_x   <= w.x;
        s_comp_y   <= w.y;
        s_comp_z   <= w.z;
        s_half_len <= w.hl;
        s_last     <= w.last;
        do @(posedge aclk); while (!s_ready);
        if (w.slot == 2'd3) begin
            ctr_q[w.box][0] = w.x;
            ctr_q[w.box][1] = w.y;
            ctr_q[w.box][2] = w.z;
        end else begin
            axis_q[w.box][w.slot][0] = w.x;
            axis_q[w.box][w.slot][1] = w.y;
            axis_q[w.box][w.slot][2] = w.z;
            ext_q[w.box][w.slot] = w.hl;
        end
        if (w.last) begin
            if (w.known) begin
                v.ov = w.ov;
                v.sep = w.sep;
            end else begin
                v.sep = find_separating_axis();
                v.ov = (v.sep == NO_AXIS);
            end
            verdict_q.push_back(v);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off that backs the block up.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        verdict_t v;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                report("unexpected word, overlap", -1, m_overlap);
            end else begin
                v = verdict_q.pop_front();
                if (m_overlap !== v.ov) report("overlap", v.ov, m_overlap);
                if (m_separating_axis !== v.sep) report("separating_axis", v.sep, m_separating_axis);
            end
        end
    end

    initial begin
        int    sent;
        int    phase;
        int    kind;
        int    cnt;
        int    order[8];
        int    tmp;
        int    pick;
        word_t w;
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_box = 1'b0;
        s_slot = 2'd0;
        s_comp_x = 0;
        s_comp_y = 0;
        s_comp_z = 0;
        s_half_len = 0;
        s_last = 1'b0;
        m_ready = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Unit cubes, then shifted, extreme, degenerate and rotated cases.
        plan.push_back(mk(0, 0, ONE, 0, 0, ONE, 0));
        plan.push_back(mk(0, 1, 0, ONE, 0, ONE, 0));
        plan.push_back(mk(0, 2, 0, 0, ONE, ONE, 0));
        plan.push_back(mk(0, 3, 0, 0, 0, 31'h7FFF_FFFF, 0));
        plan.push_back(mk(1, 0, ONE, 0, 0, ONE, 0));
        plan.push_back(mk(1, 1, 0, ONE, 0, ONE, 0));
        plan.push_back(mk(1, 2, 0, 0, ONE, ONE, 0));
        plan.push_back(mk_known(mk(1, 3, 0, 0, 0, 0, 1), 1'b1, NO_AXIS));
        plan.push_back(mk_known(mk(1, 3, 3 * ONE, 0, 0, 0, 1), 1'b0, 4'd0));
        plan.push_back(mk_known(mk(1, 3, 0, 0, -3 * ONE, 0, 1), 1'b0, 4'd2));
        plan.push_back(mk(0, 3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h5555_5555, 1));
        plan.push_back(mk(1, 3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1));
        plan.push_back(mk(1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF, 1));
        plan.push_back(mk(0, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1));
        plan.push_back(mk(0, 3, 0, 0, 0, 0, 0));
        plan.push_back(mk(0, 1, 0, ONE, 0, ONE, 0));
        plan.push_back(mk(1, 0, 46341, 46341, 0, ONE, 0));
        plan.push_back(mk(1, 1, -46341, 46341, 0, ONE, 0));
        plan.push_back(mk(1, 3, 2 * ONE + 40000, 2 * ONE + 40000, 0, 0, 1));
        plan.push_back(mk(1, 3, ONE, 2 * ONE, ONE / 2, 0, 1));
        plan.push_back(mk(1, 2, 30000, -20000, ONE, 3 * ONE, 1));
        while (plan.size() > 0) send_word(plan.pop_front());

        sent = 0;
        // Long enough for several full tests, so a second verdict backs up the input.
        hold_left = 40000;
        while (sent < N_WORDS) begin
            phase = sent * 4 / N_WORDS;
            send_idle_pct  = (phase == 1) ? 77 : (phase == 3) ? 19 : 0;
            recv_stall_pct = (phase == 2) ? 77 : (phase == 3) ? 19 : 0;
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                // Whole pair of boxes in shuffled order, tested on its final word.
                for (int i = 0; i < 8; i++) order[i] = i;
                for (int i = 7; i > 0; i--) begin
                    pick = $urandom_range(0, i);
                    tmp = order[i]; order[i] = order[pick]; order[pick] = tmp;
                end
                for (int i = 0; i < 8; i++) begin
                    plan.push_back(rand_word(order[i][2], order[i][1:0], i == 7));
                end
            end else if (kind < 9) begin
                cnt = $urandom_range(1, 3);
                for (int i = 0; i < cnt; i++) begin
                    plan.push_back(rand_word(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                             i == cnt - 1));
                end
            end else begin
                cnt = $urandom_range(1, 4);
                for (int i = 0; i < cnt; i++) begin
                    w = rand_word(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 1'b0);
                    w.last = ($urandom_range(0, 3) == 0);
                    plan.push_back(w);
                end
            end
            while (plan.size() > 0) begin
                send_word(plan.pop_front());
                sent++;
            end
        end
        @(negedge aclk);
        s_valid <= 1'b0;
        recv_stall_pct = 0;

        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (12000) @(posedge aclk);
        if (verdict_q.size() != 0) report("words still owed", 0, verdict_q.size());
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: obb_overlap_test_top.f
+incdir+hw/rtl
hw/rtl/obb_pkg.sv
hw/rtl/obb_store.sv
hw/rtl/obb_dp.sv
hw/rtl/obb_seq.sv
hw/rtl/obb_overlap_test_top.sv
hw/rtl/obb_overlap_test_chk.sv
tb/obb_overlap_test_top_tb.sv
